/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default geometry
    localparam int unsigned DEF_COLUMNS  = 80;
    localparam int unsigned DEF_ROWS     = 25;
    localparam int unsigned DEF_TAB_STOP = 8;

    // Control codes
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0a;
    localparam logic [7:0] CODE_CR  = 8'h0d;

    // Register indexes and reset values
    localparam logic CFG_CHAR_ATTR = 1'b0;
    localparam logic CFG_OUTPUT_EN = 1'b1;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    typedef enum logic [1:0] {
        REQ_PRINT = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } cell_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

/* design/tcw_addr_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared address unit: maps a screen row and column to a cell store address,
// applying the scroll offset modulo the row count.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
    parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS,
    parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int unsigned RW      = $clog2(ROWS),
    parameter int unsigned CW      = $clog2(COLUMNS),
    parameter int unsigned AW      = $clog2(ROWS * COLUMNS)
) (
    input  logic [RW-1:0] scr_row,
    input  logic [RW-1:0] top_row,
    input  logic [CW-1:0] col,
    output logic [AW-1:0] addr
);

    localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

    logic [RW:0]   row_sum;
    logic [RW-1:0] store_row;

    always_comb begin
        row_sum = {1'b0, scr_row} + {1'b0, top_row};
        // wrap once: both terms are below the row count
        if (row_sum >= (RW + 1)'(ROWS)) begin
            store_row = RW'(row_sum - (RW + 1)'(ROWS));
        end else begin
            store_row = RW'(row_sum);
        end
        addr = AW'(store_row) * COLS_A + AW'(col);
    end

endmodule

/* design/tcw_cell_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_mem
// Single-port character/attribute cell store with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_mem #(
    parameter int unsigned DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  tcw_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    input  tcw_pkg::cell_t    wdata,
    output tcw_pkg::cell_t    rdata
);
    import tcw_pkg::*;

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[addr] <= wdata;
        end
        if (ctl.re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/text_console_writer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: prints bytes, clears the screen, reads cells.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_tready is high only while the block is
// idle. A print request passes through transfer, execute and result steps,
// and a cell read adds one more step for the registered memory read. A new
// line on the bottom row adds a sweep that clears the new bottom row, and a
// clear request adds a sweep that clears the whole store; both sweeps run
// through the single cell store port, which writes one cell per cycle. After
// reset the same clearing pass runs over the whole store before the first
// request is taken. A result waiting on m_tready holds the block in its final
// step. Configuration writes land at any time.
module text_console_writer_core #(
    parameter int unsigned COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int unsigned ROWS     = tcw_pkg::DEF_ROWS,
    parameter int unsigned TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cursor_col[6:0], cursor_row[11:7],
                                   // cell_char[19:12], cell_attr[27:20]
);
    import tcw_pkg::*;

    localparam int unsigned CW    = $clog2(COLUMNS);
    localparam int unsigned RW    = $clog2(ROWS);
    localparam int unsigned PW    = $clog2(TAB_STOP);
    localparam int unsigned DEPTH = ROWS * COLUMNS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned TW    = CW + 6;

    state_t state_reg, state_next;

    // configuration
    logic [7:0] attr_reg;
    logic       oe_reg;

    // captured request
    logic [1:0] req_reg;
    logic [7:0] ch_reg;
    logic [4:0] rd_row_reg;
    logic [6:0] rd_col_reg;

    // cursor and scroll state
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [RW-1:0] top_reg, top_next;

    // clearing sweep
    logic [RW-1:0] sweep_row_reg, sweep_row_next;
    logic [CW-1:0] sweep_col_reg, sweep_col_next;
    logic          sweep_all_reg, sweep_all_next;
    logic          init_reg, init_next;

    // read result and output register
    cell_t       cell_reg, cell_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    // memory and address unit
    mem_ctl_t      mem_ctl;
    cell_t         mem_wdata;
    cell_t         mem_rdata;
    logic [AW-1:0] mem_addr;
    logic [RW-1:0] unit_row;
    logic [CW-1:0] unit_col;

    // decode
    logic          is_print, is_clear, rd_ok;
    logic          do_cr, do_lf, do_bs, do_tab, do_char;
    logic [TW-1:0] tab_sum;
    logic          tab_wrap, char_wrap, need_nl, scroll;
    logic          sweep_last, out_free;

    assign out_free   = !out_valid_reg || m_tready;
    assign sweep_last = (sweep_col_reg == CW'(COLUMNS - 1))
                        && (!sweep_all_reg || (sweep_row_reg == RW'(ROWS - 1)));

    always_comb begin
        is_print = (req_reg == REQ_PRINT) && oe_reg;
        is_clear = (req_reg == REQ_CLEAR);
        rd_ok    = (req_reg == REQ_READ) && (32'(rd_row_reg) < 32'(ROWS))
                   && (32'(rd_col_reg) < 32'(COLUMNS));
        do_cr   = 1'b0;
        do_lf   = 1'b0;
        do_bs   = 1'b0;
        do_tab  = 1'b0;
        do_char = 1'b0;
        unique case (ch_reg)
            CODE_CR:  do_cr  = is_print;
            CODE_LF:  do_lf  = is_print;
            CODE_BS:  do_bs  = is_print;
            CODE_TAB: do_tab = is_print;
            default:  do_char = is_print;
        endcase
        // phase tracks the column modulo the tab stop
        if (phase_reg != '0) begin
            tab_sum = TW'(cur_col_reg) + TW'(TAB_STOP) - TW'(phase_reg);
        end else begin
            tab_sum = TW'(cur_col_reg);
        end
        tab_wrap  = tab_sum >= TW'(COLUMNS);
        char_wrap = cur_col_reg == CW'(COLUMNS - 1);
        need_nl   = do_lf || (do_tab && tab_wrap) || (do_char && char_wrap);
        scroll    = need_nl && (cur_row_reg == RW'(ROWS - 1));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (is_clear || scroll) begin
                    state_next = ST_SWEEP;
                end else if (rd_ok) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ: state_next = ST_FINISH;
            ST_SWEEP: begin
                if (sweep_last) begin
                    state_next = init_reg ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        phase_next     = phase_reg;
        top_next       = top_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        sweep_all_next = sweep_all_reg;
        init_next      = init_reg;
        cell_next      = cell_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_ctl        = '0;
        mem_wdata      = '0;
        unit_row       = cur_row_reg;
        unit_col       = cur_col_reg;

        unique case (state_reg)
            ST_IDLE: ;
            ST_EXEC: begin
                cell_next = '0;
                if (rd_ok) begin
                    unit_row   = RW'(rd_row_reg);
                    unit_col   = CW'(rd_col_reg);
                    mem_ctl.re = 1'b1;
                end
                if (do_char) begin
                    mem_ctl.we   = 1'b1;
                    mem_wdata.ch   = ch_reg;
                    mem_wdata.attr = attr_reg;
                    cur_col_next = cur_col_reg + CW'(1);
                    phase_next   = (phase_reg == PW'(TAB_STOP - 1)) ? '0
                                   : phase_reg + PW'(1);
                end
                if (do_cr) begin
                    cur_col_next = '0;
                    phase_next   = '0;
                end
                if (do_bs && (cur_col_reg != '0)) begin
                    cur_col_next = cur_col_reg - CW'(1);
                    phase_next   = (phase_reg == '0) ? PW'(TAB_STOP - 1)
                                   : phase_reg - PW'(1);
                end
                if (do_tab) begin
                    cur_col_next = CW'(tab_sum);
                    phase_next   = '0;
                end
                if (need_nl) begin
                    cur_col_next = '0;
                    phase_next   = '0;
                    if (scroll) begin
                        top_next = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
                        sweep_row_next = RW'(ROWS - 1);
                        sweep_col_next = '0;
                        sweep_all_next = 1'b0;
                    end else begin
                        cur_row_next = cur_row_reg + RW'(1);
                    end
                end
                if (is_clear) begin
                    cur_col_next   = '0;
                    cur_row_next   = '0;
                    phase_next     = '0;
                    top_next       = '0;
                    sweep_row_next = '0;
                    sweep_col_next = '0;
                    sweep_all_next = 1'b1;
                end
            end
            ST_READ: cell_next = mem_rdata;
            ST_SWEEP: begin
                unit_row   = sweep_row_reg;
                unit_col   = sweep_col_reg;
                mem_ctl.we = 1'b1;
                if (sweep_col_reg == CW'(COLUMNS - 1)) begin
                    sweep_col_next = '0;
                    sweep_row_next = sweep_row_reg + RW'(1);
                end else begin
                    sweep_col_next = sweep_col_reg + CW'(1);
                end
                if (sweep_last) begin
                    init_next = 1'b0;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, cell_reg.attr, cell_reg.ch,
                                      5'(cur_row_reg), 7'(cur_col_reg)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            attr_reg      <= ATTR_RESET;
            oe_reg        <= 1'b1;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            phase_reg     <= '0;
            top_reg       <= '0;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            sweep_all_reg <= 1'b1;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            phase_reg     <= phase_next;
            top_reg       <= top_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            sweep_all_reg <= sweep_all_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_CHAR_ATTR: attr_reg <= cfg_data;
                    CFG_OUTPUT_EN: oe_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload: capture on input transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg    <= s_tuser;
            ch_reg     <= s_tdata[7:0];
            rd_row_reg <= s_tdata[12:8];
            rd_col_reg <= s_tdata[19:13];
        end
        cell_reg     <= cell_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    tcw_addr_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .RW      (RW),
        .CW      (CW),
        .AW      (AW)
    ) u_addr (
        .scr_row (unit_row),
        .top_row (top_reg),
        .col     (unit_col),
        .addr    (mem_addr)
    );

    tcw_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

/* test/tb_text_console_writer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// Self-checking bench for the text console writer core.
// ----------------------------------------------------------------------------
// Requests go in from a queue through a randomly idling stream driver. Each
// accepted request is run through a local console model (cell store, cursor,
// scroll offset, attribute and enable registers), which queues the cursor and
// cell status the block must return. A monitor with random back-pressure
// compares every returned status field by field. A short directed sequence is
// followed by configuration phases of random text lines, cell reads, clears
// and unused request codes.
// ----------------------------------------------------------------------------
module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int unsigned COLS  = DEF_COLUMNS;
    localparam int unsigned ROWS  = DEF_ROWS;
    localparam int unsigned TAB   = DEF_TAB_STOP;
    localparam int unsigned CELLS = COLS * ROWS;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic [4:0] row;
        logic [6:0] col;
    } request_t;

    // cursor_col lowest, as in m_tdata
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // char_code[7:0], read_row[12:8], read_col[19:13]
    logic [1:0]  s_tuser = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // cursor_col[6:0], cursor_row[11:7],
                                 // cell_char[19:12], cell_attr[27:20]

    text_console_writer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Console model state
    cell_t       screen_mem [CELLS] = '{default: '0};
    int unsigned crs_col = 0;
    int unsigned crs_row = 0;
    int unsigned top_ofs = 0;
    logic [7:0]  attr_reg = ATTR_RESET;
    logic        out_en = 1'b1;

    request_t pending_q[$];
    status_t  status_q[$];
    request_t cur_req;
    status_t  want_st;
    status_t  got_st;

    int  err_count = 0;
    int  live_items = 0;
    int  sender_idle_pct = 31;
    int  recv_idle_pct = 57;
    logic hold_req = 1'b0;
    int  hold_left = 0;

    function automatic int unsigned phys_row(int unsigned screen_row);
        return (screen_row + top_ofs) % ROWS;
    endfunction

    task automatic line_feed();
        int unsigned base;
        if (crs_row < ROWS - 1) begin
            crs_row++;
        end else begin
            top_ofs = (top_ofs + 1) % ROWS;
            base = phys_row(ROWS - 1) * COLS;
            for (int i = 0; i < COLS; i++) screen_mem[base + i] = '0;
        end
        crs_col = 0;
    endtask

    task automatic print_code(logic [7:0] code);
        int unsigned rem;
        case (code)
            CODE_CR: crs_col = 0;
            CODE_LF: line_feed();
            CODE_BS: begin
                if (crs_col > 0) crs_col--;
            end
            CODE_TAB: begin
                rem = crs_col % TAB;
                if (rem != 0) crs_col += TAB - rem;
                if (crs_col >= COLS) line_feed();
            end
            default: begin
                screen_mem[phys_row(crs_row) * COLS + crs_col] = '{attr: attr_reg, ch: code};
                crs_col++;
                if (crs_col >= COLS) line_feed();
            end
        endcase
    endtask

    // Update the console model for one request and queue its status
    task automatic apply_request(request_t rq);
        status_t st;
        cell_t   c;
        st = '0;
        case (rq.kind)
            REQ_PRINT: begin
                if (out_en) print_code(rq.code);
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
                crs_col = 0;
                crs_row = 0;
                top_ofs = 0;
            end
            REQ_READ: begin
                if (rq.row < ROWS && rq.col < COLS) begin
                    c = screen_mem[phys_row(rq.row) * COLS + rq.col];
                    st.ch = c.ch;
                    st.attr = c.attr;
                end
            end
            default: ;
        endcase
        st.col = 7'(crs_col);
        st.row = 5'(crs_row);
        status_q.push_back(st);
    endtask

    task automatic queue_req(logic [1:0] kind, logic [7:0] code, logic [4:0] row,
                             logic [6:0] col);
        pending_q.push_back('{kind: kind, code: code, row: row, col: col});
        live_items++;
    endtask

    // One burst of random traffic: mostly text lines, some reads, rare clears
    task automatic queue_burst();
        int sel;
        int len;
        int pick;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            queue_req(REQ_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        end else if (sel < 7) begin
            queue_req(REQ_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
        end else if (sel < 30) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0)
                    queue_req(REQ_READ, 8'($urandom), 5'($urandom), 7'($urandom));
                else
                    queue_req(REQ_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                              7'($urandom_range(0, COLS - 1)));
            end
        end else begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 15);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 19);
                c = (pick == 0) ? CODE_BS : (pick == 1) ? CODE_TAB :
                    (pick == 2) ? CODE_CR : 8'($urandom);
                queue_req(REQ_PRINT, c, 5'($urandom), 7'($urandom));
            end
            if ($urandom_range(0, 3) == 0)
                queue_req(REQ_PRINT, CODE_CR, 5'($urandom), 7'($urandom));
            queue_req(REQ_PRINT, CODE_LF, 5'($urandom), 7'($urandom));
        end
    endtask

    task automatic wait_quiet(int settle);
        while (pending_q.size() != 0 || s_tvalid || status_q.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_config(logic [7:0] attr, logic en);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CHAR_ATTR;
        cfg_data  <= attr;
        attr_reg = attr;
        @(posedge aclk);
        cfg_index <= CFG_OUTPUT_EN;
        cfg_data  <= {7'b0, en};
        out_en = en;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Request driver: hold each transfer until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) apply_request(cur_req);
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    cur_req = pending_q.pop_front();
                    s_tdata  <= {4'b0, cur_req.col, cur_req.row, cur_req.code};
                    s_tuser  <= cur_req.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_req && hold_left == 0) hold_left <= 400;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_st = m_tdata[27:0];
                if (status_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: unexpected result col=%0d row=%0d char=%h attr=%h",
                                 got_st.col, got_st.row, got_st.ch, got_st.attr);
                end else begin
                    want_st = status_q.pop_front();
                    if (got_st.col != want_st.col || got_st.row != want_st.row ||
                        got_st.ch != want_st.ch || got_st.attr != want_st.attr) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $write("ERROR: exp col=%0d row=%0d char=%h attr=%h, ",
                                   want_st.col, want_st.row, want_st.ch, want_st.attr);
                            $display("got col=%0d row=%0d char=%h attr=%h",
                                     got_st.col, got_st.row, got_st.ch, got_st.attr);
                        end
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int phase_items [5];
        logic [7:0] attr;

        phase_items = '{500, 300, 60, 500, 600};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: default attribute, output enabled
        queue_req(REQ_READ, 8'h00, 5'd0, 7'd0);
        queue_req(REQ_PRINT, 8'h41, 5'd0, 7'd0);
        queue_req(REQ_PRINT, 8'hff, 5'd31, 7'd127);
        queue_req(REQ_PRINT, 8'h00, 5'd0, 7'd0);
        queue_req(REQ_READ, 8'hff, 5'd0, 7'd1);
        queue_req(REQ_READ, 8'h00, 5'd0, 7'd2);
        queue_req(REQ_PRINT, CODE_BS, 5'd0, 7'd0);
        queue_req(REQ_PRINT, CODE_CR, 5'd0, 7'd0);
        queue_req(REQ_PRINT, CODE_BS, 5'd0, 7'd0);   // stays at column 0
        queue_req(REQ_PRINT, CODE_TAB, 5'd0, 7'd0);  // already on a stop
        queue_req(REQ_PRINT, 8'h7e, 5'd0, 7'd0);
        // tabs out to the row end, the last one wraps to a new line
        for (int i = 0; i < 10; i++) queue_req(REQ_PRINT, CODE_TAB, 5'd0, 7'd0);
        queue_req(REQ_PRINT, CODE_LF, 5'd0, 7'd0);
        queue_req(REQ_READ, 8'h00, 5'd31, 7'd127);
        queue_req(REQ_READ, 8'h00, 5'(ROWS), 7'd5);
        queue_req(REQ_READ, 8'h00, 5'd3, 7'(COLS));
        queue_req(REQ_READ, 8'h00, 5'(ROWS - 1), 7'(COLS - 1));
        queue_req(REQ_UNUSED, 8'h41, 5'd1, 7'd1);
        wait_quiet(4);

        // Directed: output disabled, clear still works
        set_config(ATTR_RESET, 1'b0);
        queue_req(REQ_PRINT, 8'h5a, 5'd0, 7'd0);
        queue_req(REQ_PRINT, CODE_LF, 5'd0, 7'd0);
        queue_req(REQ_PRINT, CODE_TAB, 5'd0, 7'd0);
        queue_req(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
        queue_req(REQ_READ, 8'h00, 5'd0, 7'd0);
        wait_quiet(4);

        for (int p = 0; p < 5; p++) begin
            attr = (p == 0) ? 8'hff : (p == 1) ? 8'h00 : 8'($urandom);
            set_config(attr, p != 2);
            if (p == 2) begin
                sender_idle_pct = 57;
                recv_idle_pct = 31;
            end else if (p == 4) begin
                sender_idle_pct = 0;
                recv_idle_pct = 0;
            end
            live_items = 0;
            while (live_items < phase_items[p]) queue_burst();
            if (p == 4) begin
                // stall the result side while requests keep coming
                @(posedge aclk);
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
            wait_quiet(4);
        end

        wait_quiet(100);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
design/tcw_pkg.sv
design/tcw_addr_unit.sv
design/tcw_cell_mem.sv
design/text_console_writer_core.sv
test/tb_text_console_writer_core.sv
